[rtl/sldf_pkg.sv]
// Shared types and constants of the sync/length/CRC-8 frame deframer.
// Used by sldf_crc, sldf_ctrl and the top level; depends on nothing.
package sldf_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CRC_POLY      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 2'd3;

    localparam logic [7:0]  SYNC_FIRST_RST    = 8'h55;
    localparam logic [7:0]  SYNC_SECOND_RST   = 8'hAA;
    localparam logic [7:0]  CRC_POLY_RST      = 8'h07;
    localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd10000;

    localparam logic [23:0] IDLE_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_TYPE  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CRC,
        CS_READ,
        CS_LOAD,
        CS_SEND
    } ctrl_state_t;

    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_CRC_ERR  = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_TIMEOUT  = 2'd3
    } status_t;

    typedef struct packed {
        logic       start;
        logic [7:0] init;
    } crc_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } crc_rsp_t;

endpackage

[rtl/sldf_crc.sv]
// Bit-serial CRC-8 unit: one polynomial shift/xor step per cycle, eight per byte.
// Depends on sldf_pkg for the request and response structs.
module sldf_crc
    import sldf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] crc_poly,
    input  crc_req_t   req,
    output crc_rsp_t   rsp
);

    logic [7:0] c_reg, c_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic [7:0] c_step;

    // One MSB-first division step.
    assign c_step = c_reg[7] ? ({c_reg[6:0], 1'b0} ^ crc_poly) : {c_reg[6:0], 1'b0};

    always_comb
    begin
        c_next    = c_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            c_next    = req.init;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            c_next   = c_step;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign rsp.done   = busy_reg && (cnt_reg == 3'd7);
    assign rsp.result = c_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg    <= 8'd0;
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            c_reg    <= c_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

[rtl/sldf_store.sv]
// Payload byte memory: one write port and one registered read port.
// No dependencies; contents are undefined until written.
module sldf_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sldf_ctrl.sv]
// Frame sequencer: sync hunt, header and payload capture, CRC check, result delivery
// and event counters. Depends on sldf_pkg; drives sldf_crc and sldf_store.
module sldf_ctrl
    import sldf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    sync_first,
    input  logic [7:0]    sync_second,
    input  logic [23:0]   timeout_ticks,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          opcode,
    input  logic [7:0]    rx_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output status_t       status,
    output logic [7:0]    frame_type,
    output logic [6:0]    frame_len,
    output logic [7:0]    payload_byte,
    output logic [5:0]    byte_index,
    output logic          last,
    output logic [31:0]   good_frames,
    output logic [31:0]   crc_failures,
    output logic [31:0]   timeout_events,
    output logic [31:0]   overflow_events,
    output crc_req_t      crc_req,
    input  crc_rsp_t      crc_rsp,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data
);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  type_hold_reg, type_hold_next;
    logic [6:0]  length_hold_reg, length_hold_next;
    logic [6:0]  fill_reg, fill_next;
    logic [7:0]  crc_acc_reg, crc_acc_next;
    logic [23:0] idle_reg, idle_next;
    logic        seen_reg, seen_next;
    logic [31:0] good_cnt_reg, good_cnt_next;
    logic [31:0] crc_cnt_reg, crc_cnt_next;
    logic [31:0] tmo_cnt_reg, tmo_cnt_next;
    logic [31:0] ovf_cnt_reg, ovf_cnt_next;
    logic [5:0]  rd_idx_reg, rd_idx_next;
    logic        o_valid_reg, o_valid_next;
    status_t     o_status_reg, o_status_next;
    logic [7:0]  o_type_reg, o_type_next;
    logic [6:0]  o_len_reg, o_len_next;
    logic [7:0]  o_byte_reg, o_byte_next;
    logic [5:0]  o_idx_reg, o_idx_next;
    logic        o_last_reg, o_last_next;

    logic        is_tick, is_byte;
    logic [23:0] idle_inc;
    logic        timeout_hit, len_over, crc_ok;
    logic        need_crc, emit_now, start_read;
    logic [7:0]  crc_init;
    logic [6:0]  fill_inc;

    // Event decode for the item offered in the idle state.
    always_comb
    begin
        is_tick     = in_valid && (state_reg == CS_IDLE) && opcode;
        is_byte     = in_valid && (state_reg == CS_IDLE) && !opcode;
        idle_inc    = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 24'd1;
        timeout_hit = is_tick && seen_reg && (phase_reg != PH_SYNC1)
                      && (idle_inc > timeout_ticks);
        len_over    = rx_byte > 8'(MAX_PAYLOAD);
        crc_ok      = rx_byte == crc_acc_reg;
        fill_inc    = fill_reg + 7'd1;
        need_crc    = is_byte && ((phase_reg == PH_TYPE)
                      || ((phase_reg == PH_LEN) && !len_over)
                      || (phase_reg == PH_DATA));
        emit_now    = timeout_hit
                      || (is_byte && (phase_reg == PH_LEN) && len_over)
                      || (is_byte && (phase_reg == PH_CRC)
                          && (!crc_ok || (length_hold_reg == 7'd0)));
        start_read  = is_byte && (phase_reg == PH_CRC) && crc_ok
                      && (length_hold_reg != 7'd0);
        crc_init    = ((phase_reg == PH_TYPE) ? 8'd0 : crc_acc_reg) ^ rx_byte;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (need_crc)
                begin
                    state_next = CS_CRC;
                end
                else if (emit_now)
                begin
                    state_next = CS_SEND;
                end
                else if (start_read)
                begin
                    state_next = CS_READ;
                end
            end
            CS_CRC:
            begin
                if (crc_rsp.done)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_READ: state_next = CS_LOAD;
            CS_LOAD: state_next = CS_SEND;
            CS_SEND:
            begin
                if (out_ready)
                begin
                    state_next = o_last_reg ? CS_IDLE : CS_READ;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready     = state_reg == CS_IDLE;
        crc_req.start = need_crc;
        crc_req.init  = crc_init;
        wr_en        = is_byte && (phase_reg == PH_DATA);
        wr_addr      = fill_reg[AW-1:0];
        wr_data      = rx_byte;
        rd_en        = state_reg == CS_READ;
        rd_addr      = rd_idx_reg[AW-1:0];
    end

    // Frame state, counters and result register.
    always_comb
    begin
        phase_next       = phase_reg;
        type_hold_next   = type_hold_reg;
        length_hold_next = length_hold_reg;
        fill_next        = fill_reg;
        crc_acc_next     = crc_acc_reg;
        idle_next        = idle_reg;
        seen_next        = seen_reg;
        good_cnt_next    = good_cnt_reg;
        crc_cnt_next     = crc_cnt_reg;
        tmo_cnt_next     = tmo_cnt_reg;
        ovf_cnt_next     = ovf_cnt_reg;
        rd_idx_next      = rd_idx_reg;
        o_valid_next     = o_valid_reg;
        o_status_next    = o_status_reg;
        o_type_next      = o_type_reg;
        o_len_next       = o_len_reg;
        o_byte_next      = o_byte_reg;
        o_idx_next       = o_idx_reg;
        o_last_next      = o_last_reg;

        // Single-item results, flagged or an empty good frame, carry a zero byte, index zero and last set.
        if (emit_now)
        begin
            o_valid_next = 1'b1;
            o_byte_next  = 8'd0;
            o_idx_next   = 6'd0;
            o_last_next  = 1'b1;
        end

        if (is_tick)
        begin
            idle_next = idle_inc;
            if (timeout_hit)
            begin
                tmo_cnt_next  = tmo_cnt_reg + 32'd1;
                phase_next    = PH_SYNC1;
                fill_next     = 7'd0;
                crc_acc_next  = 8'd0;
                o_status_next = STAT_TIMEOUT;
                o_type_next   = 8'd0;
                o_len_next    = 7'd0;
            end
        end

        if (is_byte)
        begin
            idle_next = 24'd0;
            seen_next = 1'b1;
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == sync_second)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else if (rx_byte != sync_first)
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_TYPE:
                begin
                    type_hold_next = rx_byte;
                    phase_next     = PH_LEN;
                end
                PH_LEN:
                begin
                    fill_next = 7'd0;
                    if (len_over)
                    begin
                        // The held length stays as it was.
                        ovf_cnt_next  = ovf_cnt_reg + 32'd1;
                        phase_next    = PH_SYNC1;
                        crc_acc_next  = 8'd0;
                        o_status_next = STAT_OVERFLOW;
                        o_type_next   = type_hold_reg;
                        o_len_next    = 7'd0;
                    end
                    else
                    begin
                        length_hold_next = rx_byte[6:0];
                        phase_next = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    fill_next = fill_inc;
                    if (fill_inc >= length_hold_reg)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    fill_next    = 7'd0;
                    crc_acc_next = 8'd0;
                    if (crc_ok)
                    begin
                        good_cnt_next = good_cnt_reg + 32'd1;
                        phase_next    = PH_SYNC1;
                        rd_idx_next   = 6'd0;
                        o_status_next = STAT_GOOD;
                        o_type_next   = type_hold_reg;
                        o_len_next    = 7'd0;
                    end
                    else
                    begin
                        // A bad CRC byte that looks like a first sync byte restarts the hunt.
                        crc_cnt_next  = crc_cnt_reg + 32'd1;
                        phase_next    = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
                        o_status_next = STAT_CRC_ERR;
                        o_type_next   = type_hold_reg;
                        o_len_next    = length_hold_reg;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end

        if ((state_reg == CS_CRC) && crc_rsp.done)
        begin
            crc_acc_next = crc_rsp.result;
        end

        if (state_reg == CS_LOAD)
        begin
            o_valid_next  = 1'b1;
            o_status_next = STAT_GOOD;
            o_type_next   = type_hold_reg;
            o_len_next    = length_hold_reg;
            o_byte_next   = rd_data;
            o_idx_next    = rd_idx_reg;
            o_last_next   = ({1'b0, rd_idx_reg} + 7'd1) == length_hold_reg;
        end

        if ((state_reg == CS_SEND) && out_ready)
        begin
            o_valid_next = 1'b0;
            if (!o_last_reg)
            begin
                rd_idx_next = rd_idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= CS_IDLE;
            phase_reg       <= PH_SYNC1;
            type_hold_reg   <= 8'd0;
            length_hold_reg <= 7'd0;
            fill_reg        <= 7'd0;
            crc_acc_reg     <= 8'd0;
            idle_reg        <= 24'd0;
            seen_reg        <= 1'b0;
            good_cnt_reg    <= 32'd0;
            crc_cnt_reg     <= 32'd0;
            tmo_cnt_reg     <= 32'd0;
            ovf_cnt_reg     <= 32'd0;
            rd_idx_reg      <= 6'd0;
            o_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            type_hold_reg   <= type_hold_next;
            length_hold_reg <= length_hold_next;
            fill_reg        <= fill_next;
            crc_acc_reg     <= crc_acc_next;
            idle_reg        <= idle_next;
            seen_reg        <= seen_next;
            good_cnt_reg    <= good_cnt_next;
            crc_cnt_reg     <= crc_cnt_next;
            tmo_cnt_reg     <= tmo_cnt_next;
            ovf_cnt_reg     <= ovf_cnt_next;
            rd_idx_reg      <= rd_idx_next;
            o_valid_reg     <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_status_reg <= o_status_next;
        o_type_reg   <= o_type_next;
        o_len_reg    <= o_len_next;
        o_byte_reg   <= o_byte_next;
        o_idx_reg    <= o_idx_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid       = o_valid_reg;
    assign status          = o_status_reg;
    assign frame_type      = o_type_reg;
    assign frame_len       = o_len_reg;
    assign payload_byte    = o_byte_reg;
    assign byte_index      = o_idx_reg;
    assign last            = o_last_reg;
    assign good_frames     = good_cnt_reg;
    assign crc_failures    = crc_cnt_reg;
    assign timeout_events  = tmo_cnt_reg;
    assign overflow_events = ovf_cnt_reg;

endmodule

[rtl/sync_length_crc_frame_deframer_core.sv]
// Sync/length/CRC-8 frame deframer: top level with configuration registers.
// Depends on sldf_pkg, sldf_crc, sldf_store and sldf_ctrl.
//
// Usage: each input item on the s_axis channel is either a received byte
// (s_tuser = 0, byte in s_tdata) or one elapsed time tick (s_tuser = 1).
// The block hunts for the two-byte sync word, reads type and length, buffers
// the payload and checks a CRC-8 over type, length and payload. A good frame
// comes out on m_axis as one item per payload byte (one item for an empty
// frame), with m_tlast on the final one. CRC errors, length overflows and
// inter-byte timeouts each give one flagged item. Every output item carries
// the four wrapping event counters as they stand after the input that caused it.
// Ticks and bytes of the sync hunt are taken one per cycle while no result is
// pending; a type, length or payload byte holds the input while the bit-serial
// CRC unit steps through it one bit per cycle. A flagged or empty-frame item
// appears in the cycle after its input. Each item of a good frame passes the
// read, load and send states in turn, the first two for the registered read of
// the payload memory; the send state holds through any stall.
// s_tready is low while a byte is in the CRC unit or a result is pending, so
// a stalled receiver holds the result item and the input side waits.
// Reset clears the frame state, the counters and restores the register
// defaults; the payload memory is not cleared and needs no clearing pass.
module sync_length_crc_frame_deframer_core
    import sldf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] frame_type, [14:8] frame_len, [22:15] payload_byte,
    // [28:23] byte_index, [60:29] good_frames, [92:61] crc_failures,
    // [124:93] timeout_events, [156:125] overflow_events, [159:157] zero
    output logic [159:0]          m_tdata,
    output logic [1:0]            m_tuser,   // [1:0] status
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Address width of the payload memory; at least one bit.
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  crc_poly_reg;
    logic [23:0] timeout_ticks_reg;

    crc_req_t      crc_req;
    crc_rsp_t      crc_rsp;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    status_t     status;
    logic [7:0]  frame_type;
    logic [6:0]  frame_len;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic [31:0] good_frames, crc_failures, timeout_events, overflow_events;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg    <= SYNC_FIRST_RST;
            sync_second_reg   <= SYNC_SECOND_RST;
            crc_poly_reg      <= CRC_POLY_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SYNC_FIRST:    sync_first_reg    <= cfg_wdata[7:0];
                REG_SYNC_SECOND:   sync_second_reg   <= cfg_wdata[7:0];
                REG_CRC_POLY:      crc_poly_reg      <= cfg_wdata[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[23:0];
                default:           ;
            endcase
        end
    end

    sldf_crc u_crc (
        .clk      (clk),
        .rst_n    (rst_n),
        .crc_poly (crc_poly_reg),
        .req      (crc_req),
        .rsp      (crc_rsp)
    );

    sldf_store #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sldf_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .sync_first      (sync_first_reg),
        .sync_second     (sync_second_reg),
        .timeout_ticks   (timeout_ticks_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .opcode          (s_tuser),
        .rx_byte         (s_tdata),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .status          (status),
        .frame_type      (frame_type),
        .frame_len       (frame_len),
        .payload_byte    (payload_byte),
        .byte_index      (byte_index),
        .last            (m_tlast),
        .good_frames     (good_frames),
        .crc_failures    (crc_failures),
        .timeout_events  (timeout_events),
        .overflow_events (overflow_events),
        .crc_req         (crc_req),
        .crc_rsp         (crc_rsp),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data)
    );

    assign m_tuser = status;
    assign m_tdata = {3'b000, overflow_events, timeout_events, crc_failures,
                      good_frames, byte_index, payload_byte, frame_len, frame_type};

endmodule
